// File: src/cdad_pkg.sv
// Package for the Gregorian date adder: sequencer states, status and
// register index codes, and month/year length helpers.
// No dependencies.
package cdad_pkg;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOD   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_WALK  = 4'b1000
  } state_e;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_BASE = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BASE_DAY   = 2'd0;
  localparam cfg_idx_t CFG_BASE_MONTH = 2'd1;
  localparam cfg_idx_t CFG_BASE_YEAR  = 2'd2;

  // Field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CfgW   = 14;
  localparam int unsigned RemW   = 9;  // holds year mod 400
  localparam int unsigned LenW   = 9;  // holds up to 366

  localparam logic [YearW-1:0]  YEAR_LIMIT = 14'd9999;
  localparam logic [YearW-1:0]  LEAP_CYCLE = 14'd400;
  localparam logic [RemW-1:0]   REM_LAST   = 9'd399;
  localparam logic [MonthW-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MonthW-1:0] MONTH_DEC  = 4'd12;

  // Leap year from the year's remainder modulo 400
  function automatic logic leap_from_rem(input logic [RemW-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  // Days in month m (1 to 12)
  function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [LenW-1:0] len;
    case (m) inside
      4'd2:                     len = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 9'd30;
      default:                  len = 9'd31;
    endcase
    return len;
  endfunction

  // Days in a year
  function automatic logic [LenW-1:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

// File: src/calendar_date_add_days_core.sv
// Gregorian date adder top level: base date registers, sequencer and the
// shared day subtractor, plus the output register. Uses cdad_pkg.
//
// Usage: write base_day, base_month and base_year through the write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i) while the block is idle; writes to
// index 3 are dropped. Each request on the input channel carries a count
// of days; one result (date and status) leaves on the output channel.
// Status 0 is ok, 1 an invalid base date, 2 a result year above 9999;
// on a nonzero status the date fields are zero.
// Sequence: the request is taken, the year is reduced modulo 400 by
// repeated subtraction of 400, the base date is checked, then the walk
// steps by one whole year or one month at a time through the shared
// subtractor, and a final step loads the result. One request is in
// flight at a time; in_ready_o is high only while the sequencer is idle.
// The output register holds a finished result until taken; a stalled
// receiver holds the final step until the register frees.
// Reset: base date returns to day 1, month 1, year 1; no result pending.
module calendar_date_add_days_core #(
  parameter int unsigned ADD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  cdad_pkg::cfg_idx_t      cfg_idx_i,
  input  logic [13:0]             cfg_wdata_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ADD_WIDTH-1:0]    days_to_add_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [4:0]              result_day_o,
  output logic [3:0]              result_month_o,
  output logic [13:0]             result_year_o,
  output cdad_pkg::status_t       status_o
);
  import cdad_pkg::*;

  localparam int unsigned AccW = ADD_WIDTH + 1;

  // Base date registers
  logic [DayW-1:0]   base_day_q;
  logic [MonthW-1:0] base_month_q;
  logic [YearW-1:0]  base_year_q;

  // Working registers
  state_e            state_q, state_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [YearW-1:0]  rem_q, rem_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [DayW-1:0]   res_day_q, res_day_d;
  logic [MonthW-1:0] res_month_q, res_month_d;
  logic [YearW-1:0]  res_year_q, res_year_d;
  status_t           res_status_q, res_status_d;

  // Shared unit signals
  logic              leap;
  logic [RemW-1:0]   rem_next;
  logic [LenW-1:0]   mlen, ylen, len_sel;
  logic              take_year, take_month, base_ok;
  logic [AccW-1:0]   acc_diff;
  logic              out_free;

  // Write base date registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_day_q   <= 5'd1;
      base_month_q <= 4'd1;
      base_year_q  <= 14'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_DAY:   base_day_q   <= cfg_wdata_i[DayW-1:0];
        CFG_BASE_MONTH: base_month_q <= cfg_wdata_i[MonthW-1:0];
        CFG_BASE_YEAR:  base_year_q  <= cfg_wdata_i[YearW-1:0];
        default: ;
      endcase
    end
  end

  // Month and year lengths of the current walk position
  assign leap     = leap_from_rem(rem_q[RemW-1:0]);
  assign rem_next = (rem_q[RemW-1:0] == REM_LAST) ? '0 : rem_q[RemW-1:0] + 1'b1;
  assign mlen     = month_len(month_q, leap);
  assign ylen     = year_len(leap);

  // Choose a whole-year or a one-month step, then subtract once
  assign take_year  = (month_q == MONTH_JAN) && (acc_q > AccW'(ylen));
  assign take_month = acc_q > AccW'(mlen);
  assign len_sel    = take_year ? ylen : mlen;
  assign acc_diff   = acc_q - AccW'(len_sel);

  // Base date check, valid once rem_q holds the year mod 400
  assign base_ok = (month_q inside {[4'd1:4'd12]}) && (year_q != '0) &&
                   (base_day_q != '0) && (LenW'(base_day_q) <= mlen);

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    month_d      = month_q;
    year_d       = year_q;
    rem_d        = rem_q;
    out_load     = 1'b0;
    res_day_d    = '0;
    res_month_d  = '0;
    res_year_d   = '0;
    res_status_d = STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_d   = AccW'(days_to_add_i) + AccW'(base_day_q);
          month_d = base_month_q;
          year_d  = base_year_q;
          rem_d   = base_year_q;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        // reduce the year modulo 400
        if (rem_q >= LEAP_CYCLE) begin
          rem_d = rem_q - LEAP_CYCLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (base_ok) begin
          state_d = ST_WALK;
        end else if (out_free) begin
          out_load     = 1'b1;
          res_status_d = STATUS_BAD_BASE;
          state_d      = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (year_q > YEAR_LIMIT) begin
          if (out_free) begin
            out_load     = 1'b1;
            res_status_d = STATUS_OVERFLOW;
            state_d      = ST_IDLE;
          end
        end else if (take_year) begin
          acc_d  = acc_diff;
          year_d = year_q + 1'b1;
          rem_d  = YearW'(rem_next);
        end else if (take_month) begin
          acc_d = acc_diff;
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + 1'b1;
            rem_d   = YearW'(rem_next);
          end else begin
            month_d = month_q + 1'b1;
          end
        end else if (out_free) begin
          out_load     = 1'b1;
          res_day_d    = acc_q[DayW-1:0];
          res_month_d  = month_q;
          res_year_d   = year_q;
          res_status_d = STATUS_OK;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    month_q <= month_d;
    year_q  <= year_d;
    rem_q   <= rem_d;
    if (out_load) begin
      res_day_q    <= res_day_d;
      res_month_q  <= res_month_d;
      res_year_q   <= res_year_d;
      res_status_q <= res_status_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_day_o   = res_day_q;
  assign result_month_o = res_month_q;
  assign result_year_o  = res_year_q;
  assign status_o       = res_status_q;

endmodule

// File: src/cdad_checker.sv
// Port-level checks for the Gregorian date adder, bound to the top level.
// Uses cdad_pkg for the status codes.
module cdad_checker #(
  parameter int unsigned ADD_WIDTH = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [ADD_WIDTH-1:0] days_to_add_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [4:0]           result_day_o,
  input logic [3:0]           result_month_o,
  input logic [13:0]          result_year_o,
  input cdad_pkg::status_t    status_o
);
  import cdad_pkg::*;

  // One request at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // A waiting request holds its day count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(days_to_add_i))
    else $error("waiting request changed");

  // Error results carry a zero date, and status never takes code 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |->
      (status_o == STATUS_BAD_BASE || status_o == STATUS_OVERFLOW) &&
      result_day_o == '0 && result_month_o == '0 && result_year_o == '0)
    else $error("bad error result");

  // Ok results are real dates within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |->
      result_day_o != '0 && result_month_o != '0 && result_month_o <= 4'd12 &&
      result_year_o != '0 && result_year_o <= YEAR_LIMIT)
    else $error("ok result out of range");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(result_day_o) && $stable(result_month_o) && $stable(result_year_o))
    else $error("stalled result changed");

endmodule

bind calendar_date_add_days_core cdad_checker #(.ADD_WIDTH(ADD_WIDTH)) u_cdad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .days_to_add_i  (days_to_add_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_day_o   (result_day_o),
  .result_month_o (result_month_o),
  .result_year_o  (result_year_o),
  .status_o       (status_o)
);
